// ===== src/scfb_pkg.sv =====
// shared types and constants for the sensor command frame builder
`default_nettype none

package scfb_pkg;

    localparam int BURST_MAX = 11;
    localparam int BURST_CNT_W = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_CODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 2'd1;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    localparam logic [15:0] START_CODE_RESET = 16'hEF01;
    localparam logic [31:0] DEVICE_ADDRESS_RESET = 32'hFFFF_FFFF;

    localparam logic [BURST_CNT_W-1:0] HEADER_BYTES = 4'd9;
    localparam logic [BURST_CNT_W-1:0] SHORT_FRAME_BYTES = 4'd11;
    localparam logic [BURST_CNT_W-1:0] CLOSING_BYTES = 4'd3;

    // bytes caused by one input item, byte 0 goes out first
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [BURST_CNT_W-1:0] count;
        logic ends_frame;
    } burst_t;

endpackage

`default_nettype wire

// ===== src/scfb_frame_core.sv =====
// frame state and per-item byte burst generation
`default_nettype none

module scfb_frame_core
    import scfb_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic take,
    input wire logic action,
    input wire logic [7:0] frame_type,
    input wire logic [15:0] frame_length,
    input wire logic [7:0] payload_byte,
    input wire logic [15:0] start_code,
    input wire logic [31:0] device_address,
    output burst_t burst
);

    logic frame_open_reg, frame_open_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] header_sum;
    logic [15:0] payload_sum;
    logic [15:0] remaining_dec;

    assign header_sum = 16'({8'h00, frame_length[15:8]}) + 16'({8'h00, frame_length[7:0]})
                      + 16'({8'h00, frame_type});
    assign payload_sum = sum_reg + {8'h00, payload_byte};
    assign remaining_dec = remaining_reg - 16'd1;

    always_comb
    begin
        burst = '0;
        frame_open_next = frame_open_reg;
        remaining_next = remaining_reg;
        sum_next = sum_reg;
        unique case (action)
            ACT_START:
            begin
                burst.bytes[0] = start_code[15:8];
                burst.bytes[1] = start_code[7:0];
                burst.bytes[2] = device_address[31:24];
                burst.bytes[3] = device_address[23:16];
                burst.bytes[4] = device_address[15:8];
                burst.bytes[5] = device_address[7:0];
                burst.bytes[6] = frame_type;
                burst.bytes[7] = frame_length[15:8];
                burst.bytes[8] = frame_length[7:0];
                sum_next = header_sum;
                if (frame_length <= 16'd2)
                begin
                    // no payload, checksum follows the header
                    burst.bytes[9] = header_sum[15:8];
                    burst.bytes[10] = header_sum[7:0];
                    burst.count = SHORT_FRAME_BYTES;
                    burst.ends_frame = 1'b1;
                    frame_open_next = 1'b0;
                    remaining_next = '0;
                end
                else
                begin
                    burst.count = HEADER_BYTES;
                    frame_open_next = 1'b1;
                    remaining_next = frame_length - 16'd2;
                end
            end
            ACT_PAYLOAD:
            begin
                if (frame_open_reg)
                begin
                    burst.bytes[0] = payload_byte;
                    sum_next = payload_sum;
                    remaining_next = remaining_dec;
                    if (remaining_dec == 16'd0)
                    begin
                        burst.bytes[1] = payload_sum[15:8];
                        burst.bytes[2] = payload_sum[7:0];
                        burst.count = CLOSING_BYTES;
                        burst.ends_frame = 1'b1;
                        frame_open_next = 1'b0;
                    end
                    else
                    begin
                        burst.count = 4'd1;
                    end
                end
            end
            default:
            begin
                burst = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            remaining_reg <= '0;
            sum_reg <= '0;
        end
        else if (take)
        begin
            frame_open_reg <= frame_open_next;
            remaining_reg <= remaining_next;
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sensor_command_frame_builder.sv =====
// top level: config registers, frame core and output byte serializer
//
// channel  signals                               role
// item     item_valid/item_ready + input fields   start or payload item in
// result   result_valid/result_ready + out fields one frame byte out
// cfg      cfg_valid/cfg_ready, cfg_index, data   register write, always ready
//
// an item is taken in the cycle its burst is computed; its bytes then leave
// one per cycle, while result_ready holds, from the output shift register; an
// item makes 1 to 11 bytes (0 for a dropped byte) and holds the output until
// the last of them transfers; the next item is taken as that last byte transfers
// reset clears the frame state and the output byte count and restores the registers
`default_nettype none

module sensor_command_frame_builder
    import scfb_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic item_valid,
    output logic item_ready,
    input wire logic action,
    input wire logic [7:0] frame_type,
    input wire logic [15:0] frame_length,
    input wire logic [7:0] payload_byte,
    output logic result_valid,
    input wire logic result_ready,
    output logic [7:0] out_byte,
    output logic run_last,
    output logic frame_end,
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire logic [CFG_INDEX_W-1:0] cfg_index,
    input wire logic [31:0] cfg_data
);

    logic [15:0] start_code_reg;
    logic [31:0] device_address_reg;
    logic [BURST_MAX-1:0][7:0] bytes_reg;
    logic [BURST_CNT_W-1:0] count_reg;
    logic ends_reg;
    logic item_xfer;
    logic result_xfer;
    burst_t burst;

    assign cfg_ready = 1'b1;
    assign result_valid = (count_reg != '0);
    assign result_xfer = result_valid && result_ready;
    assign item_ready = (count_reg == '0) || ((count_reg == 4'd1) && result_ready);
    assign item_xfer = item_valid && item_ready;

    assign out_byte = bytes_reg[0];
    assign run_last = (count_reg == 4'd1);
    assign frame_end = ends_reg && (count_reg == 4'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= START_CODE_RESET;
            device_address_reg <= DEVICE_ADDRESS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START_CODE:     start_code_reg <= cfg_data[15:0];
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    scfb_frame_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (item_xfer),
        .action         (action),
        .frame_type     (frame_type),
        .frame_length   (frame_length),
        .payload_byte   (payload_byte),
        .start_code     (start_code_reg),
        .device_address (device_address_reg),
        .burst          (burst)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ends_reg <= 1'b0;
        end
        else if (item_xfer)
        begin
            count_reg <= burst.count;
            ends_reg <= burst.ends_frame;
        end
        else if (result_xfer)
        begin
            count_reg <= count_reg - 4'd1;
        end
    end

    // burst bytes, shifted down one byte per transfer
    always_ff @(posedge clk)
    begin
        if (item_xfer)
            bytes_reg <= burst.bytes;
        else if (result_xfer)
            bytes_reg <= bytes_reg >> 8;
    end

    property p_end_is_last;
        @(posedge clk) disable iff (!rst_n)
        (result_valid && frame_end) |-> run_last;
    endproperty
    a_end_is_last: assert property (p_end_is_last)
        else $error("frame end on a byte that is not the last of its burst");

    property p_no_take_mid_burst;
        @(posedge clk) disable iff (!rst_n)
        (count_reg > 4'd1) |-> !item_ready;
    endproperty
    a_no_take_mid_burst: assert property (p_no_take_mid_burst)
        else $error("item taken while a burst still has bytes queued");

    property p_burst_continues;
        @(posedge clk) disable iff (!rst_n)
        (result_xfer && !run_last) |=> result_valid;
    endproperty
    a_burst_continues: assert property (p_burst_continues)
        else $error("burst stopped before its last byte");

    property p_start_burst_len;
        @(posedge clk) disable iff (!rst_n)
        (item_xfer && (action == ACT_START)) |=>
            (count_reg == HEADER_BYTES) || (count_reg == SHORT_FRAME_BYTES);
    endproperty
    a_start_burst_len: assert property (p_start_burst_len)
        else $error("start item produced a burst of the wrong length");

endmodule

`default_nettype wire
